// File: rtl/pwm_speed_ramp_with_jog_macros.svh
// Assertion macros for the PWM speed ramp with jog.
`ifndef PWM_SPEED_RAMP_WITH_JOG_MACROS_SVH
`define PWM_SPEED_RAMP_WITH_JOG_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define PSRJ_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psrj assertion failed");

// Next-cycle implication.
`define PSRJ_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psrj assertion failed");

`else

`define PSRJ_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define PSRJ_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// File: rtl/psrj_pkg.sv
// Shared types and constants for the PWM speed ramp with jog.
package psrj_pkg;

  localparam int INTERVAL_BITS_DEFAULT = 16;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_CHANGE = 2'd1;
  localparam logic [1:0] CMD_HOLD   = 2'd2;

  localparam logic [1:0] JOG_OFF  = 2'd0;
  localparam logic [1:0] JOG_UP   = 2'd1;
  localparam logic [1:0] JOG_DOWN = 2'd2;

  localparam logic [2:0] REG_JOG_IV      = 3'd0;
  localparam logic [2:0] REG_UP_FITTED   = 3'd1;
  localparam logic [2:0] REG_DN_FITTED   = 3'd2;
  localparam logic [2:0] REG_GATE_FITTED = 3'd3;
  localparam logic [2:0] REG_GATE_LEVEL  = 3'd4;

  localparam logic [7:0] LEVEL_MAX = 8'hFF;

  typedef struct packed {
    logic [15:0] jog_iv;
    logic        up_fitted;
    logic        dn_fitted;
    logic        gate_fitted;
    logic        gate_level;
  } cfg_t;

  typedef struct packed {
    logic upper_stop;
    logic lower_stop;
    logic upper;
    logic lower;
    logic changing;
    logic enabled;
  } status_t;

endpackage

// File: rtl/psrj_step.sv
// Next-state logic for one command of the speed ramp.
module psrj_step #(
  parameter int INTERVAL_BITS = psrj_pkg::INTERVAL_BITS_DEFAULT
) (
  input  logic [1:0]               cmd,
  input  logic signed [15:0]       req_speed,
  input  logic [15:0]              req_iv,
  input  logic                     up_level,
  input  logic                     dn_level,
  input  logic                     gate_in,
  input  psrj_pkg::cfg_t           cfg,
  input  logic [7:0]               cur,
  input  logic [7:0]               tgt,
  input  logic [INTERVAL_BITS-1:0] civ,
  input  logic [INTERVAL_BITS-1:0] ttw,
  input  psrj_pkg::status_t        st,
  output logic [7:0]               cur_next,
  output logic [7:0]               tgt_next,
  output logic [INTERVAL_BITS-1:0] civ_next,
  output logic [INTERVAL_BITS-1:0] ttw_next,
  output psrj_pkg::status_t        st_next,
  output logic [1:0]               jog
);
  import psrj_pkg::*;

  localparam logic [32:0] IV_MAX = (33'd1 << INTERVAL_BITS) - 33'd1;
  localparam logic [INTERVAL_BITS-1:0] IV_ONE = {{(INTERVAL_BITS-1){1'b0}}, 1'b1};

  function automatic logic [INTERVAL_BITS-1:0] sat_iv(input logic [15:0] v);
    logic [32:0] ext;
    ext = {17'd0, v};
    if (ext > IV_MAX) begin
      sat_iv = IV_MAX[INTERVAL_BITS-1:0];
    end else begin
      sat_iv = ext[INTERVAL_BITS-1:0];
    end
  endfunction

  logic        gate_ok;
  logic        idle_tick;
  logic        down;
  logic [7:0]  stepped;
  logic        req_eq;
  logic [15:0] iv_eff;
  logic [7:0]  req_clamped;

  assign gate_ok = (cfg.jog_iv != 16'd0) && (!cfg.gate_fitted || gate_in == cfg.gate_level);

  always_comb begin
    jog = JOG_OFF;
    if (gate_ok && cmd == CMD_TICK) begin
      if (cfg.up_fitted && !up_level) begin
        jog = JOG_UP;
      end else if (cfg.dn_fitted && !dn_level) begin
        jog = JOG_DOWN;
      end
    end
  end

  assign idle_tick = (jog == JOG_OFF) && (tgt == cur || civ == '0);
  assign down = (jog == JOG_DOWN) || (jog == JOG_OFF && tgt < cur);
  assign stepped = down ? cur - 8'd1 : cur + 8'd1;

  assign req_eq = (req_speed[15:8] == 8'd0) && (req_speed[7:0] == tgt);
  assign iv_eff = (cfg.jog_iv != 16'd0 && req_iv < cfg.jog_iv) ? cfg.jog_iv : req_iv;
  assign req_clamped = req_speed[15] ? 8'd0 :
                       (req_speed[14:8] != 7'd0) ? LEVEL_MAX : req_speed[7:0];

  always_comb begin
    cur_next = cur;
    tgt_next = tgt;
    civ_next = civ;
    ttw_next = ttw;
    st_next  = st;
    case (cmd)
      CMD_TICK: begin
        st_next.lower = (cur == 8'd0);
        st_next.upper = (cur == LEVEL_MAX);
        if (idle_tick) begin
          tgt_next = cur;
          civ_next = '0;
          st_next.changing = 1'b0;
          st_next.enabled = (cur != 8'd0);
        end else if (ttw != '0) begin
          ttw_next = ttw - IV_ONE;
        end else begin
          if (down && cur == 8'd0) begin
            tgt_next = cur;
            st_next.lower_stop = 1'b1;
            st_next.enabled = 1'b0;
          end else if (!down && cur == LEVEL_MAX) begin
            tgt_next = cur;
            st_next.upper_stop = 1'b1;
            st_next.enabled = 1'b1;
          end else begin
            st_next.lower_stop = 1'b0;
            st_next.upper_stop = 1'b0;
            cur_next = stepped;
            st_next.enabled = (stepped != 8'd0);
            if (jog != JOG_OFF) begin
              ttw_next = sat_iv(cfg.jog_iv - 16'd1);
            end else begin
              ttw_next = civ - IV_ONE;
            end
          end
        end
      end
      CMD_CHANGE: begin
        if (!req_eq && req_iv != 16'd0) begin
          tgt_next = req_clamped;
          civ_next = sat_iv(iv_eff);
          ttw_next = '0;
          st_next.changing = 1'b1;
        end
      end
      CMD_HOLD: begin
        tgt_next = cur;
        civ_next = '0;
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

endmodule

// File: rtl/pwm_speed_ramp_with_jog.sv
// PWM speed ramp with jog override: top level with stream ports and register port.
// One request is taken every clock cycle. A request passes an input register, then the
// next-state logic (psrj_step), which updates the speed state and loads the result
// register. The result register frees as it is taken, so full rate holds while the sink
// keeps tready high. Commands: tick steps the speed toward the target (or the jog
// direction) once its wait count runs out; change sets target and interval; hold sets
// the target to the current speed and clears the interval.
`include "pwm_speed_ramp_with_jog_macros.svh"
module pwm_speed_ramp_with_jog #(
  parameter int INTERVAL_BITS = psrj_pkg::INTERVAL_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // requested_speed[15:0], step_interval[31:16], jog_up_level[32], jog_down_level[33],
  // jog_gate_input[34], zero fill[39:35]
  input  logic [39:0] s_tdata,
  // command[1:0]
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // speed[7:0], driver_enable[8], changing[9], at_lower_limit[10], at_upper_limit[11],
  // lower_limit_stop[12], upper_limit_stop[13], active_interval[29:14], jog_state[31:30]
  output logic [31:0] m_tdata,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import psrj_pkg::*;

  cfg_t cfg;

  logic               in_valid;
  logic [1:0]         in_cmd;
  logic signed [15:0] in_req;
  logic [15:0]        in_iv;
  logic               in_up;
  logic               in_dn;
  logic               in_gate;
  logic               fire;

  logic [7:0]               cur;
  logic [7:0]               tgt;
  logic [INTERVAL_BITS-1:0] civ;
  logic [INTERVAL_BITS-1:0] ttw;
  status_t                  st;

  logic [7:0]               cur_next;
  logic [7:0]               tgt_next;
  logic [INTERVAL_BITS-1:0] civ_next;
  logic [INTERVAL_BITS-1:0] ttw_next;
  status_t                  st_next;
  logic [1:0]               jog;
  logic [32:0]              civ_ext;

  logic [2:0] reg_idx;
  logic       cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_JOG_IV:      cfg.jog_iv <= pwdata[15:0];
        REG_UP_FITTED:   cfg.up_fitted <= pwdata[0];
        REG_DN_FITTED:   cfg.dn_fitted <= pwdata[0];
        REG_GATE_FITTED: cfg.gate_fitted <= pwdata[0];
        REG_GATE_LEVEL:  cfg.gate_level <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_JOG_IV:      prdata = {16'd0, cfg.jog_iv};
      REG_UP_FITTED:   prdata = {31'd0, cfg.up_fitted};
      REG_DN_FITTED:   prdata = {31'd0, cfg.dn_fitted};
      REG_GATE_FITTED: prdata = {31'd0, cfg.gate_fitted};
      REG_GATE_LEVEL:  prdata = {31'd0, cfg.gate_level};
      default:         prdata = 32'd0;
    endcase
  end

  assign fire     = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= s_tuser;
      in_req  <= s_tdata[15:0];
      in_iv   <= s_tdata[31:16];
      in_up   <= s_tdata[32];
      in_dn   <= s_tdata[33];
      in_gate <= s_tdata[34];
    end
  end

  psrj_step #(
    .INTERVAL_BITS(INTERVAL_BITS)
  ) u_step (
    .cmd      (in_cmd),
    .req_speed(in_req),
    .req_iv   (in_iv),
    .up_level (in_up),
    .dn_level (in_dn),
    .gate_in  (in_gate),
    .cfg      (cfg),
    .cur      (cur),
    .tgt      (tgt),
    .civ      (civ),
    .ttw      (ttw),
    .st       (st),
    .cur_next (cur_next),
    .tgt_next (tgt_next),
    .civ_next (civ_next),
    .ttw_next (ttw_next),
    .st_next  (st_next),
    .jog      (jog)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
      tgt <= '0;
      civ <= '0;
      ttw <= '0;
      st  <= '0;
    end else if (fire) begin
      cur <= cur_next;
      tgt <= tgt_next;
      civ <= civ_next;
      ttw <= ttw_next;
      st  <= st_next;
    end
  end

  assign civ_ext = {{(33 - INTERVAL_BITS){1'b0}}, civ_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {jog, civ_ext[15:0], st_next.upper_stop, st_next.lower_stop,
                  st_next.upper, st_next.lower, st_next.changing, st_next.enabled,
                  cur_next};
    end
  end

  `PSRJ_ASSERT_NOW(a_enable_tracks_speed, clk, rst, 1'b1, st.enabled == (cur != 8'd0))
  `PSRJ_ASSERT_NOW(a_stops_exclusive, clk, rst, 1'b1, !(st.lower_stop && st.upper_stop))
  `PSRJ_ASSERT_NEXT(a_single_step, clk, rst, fire,
    cur == $past(cur) || cur == $past(cur) + 8'd1 || cur == $past(cur) - 8'd1)
  `PSRJ_ASSERT_NEXT(a_result_follows_fire, clk, rst, fire, m_tvalid && m_tdata[7:0] == cur)

endmodule
